### sv/lbpr_pkg.sv
package lbpr_pkg;

   // fixed shape of the block
   localparam int GROUPS         = 3;
   localparam int MEMBERS        = 3;
   localparam int LEDS           = GROUPS * MEMBERS;
   localparam int TICKS_PER_WAVE = 2000;
   localparam int SEGMENTS       = 20;
   localparam int PWM_PERIOD     = 20;
   localparam int DUTY_LEN       = 20;

   // widths
   localparam int CNT_W    = 11;
   localparam int MEMBER_W = 2;
   localparam int CSR_IDX_W = 3;
   localparam int SEG_W    = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam int PH_W     = $clog2(PWM_PERIOD);
   localparam int PH_SUM_W = PH_W + 1;
   localparam int LO_W     = 6;
   localparam int HI_W     = CNT_W - LO_W;

   typedef logic [CNT_W-1:0]    cnt_type;
   typedef logic [MEMBER_W-1:0] member_type;
   typedef logic [SEG_W-1:0]    seg_type;
   typedef logic [PH_W-1:0]     ph_type;
   typedef logic [7:0]          duty_type;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_LED2   = 3'd0,
      CSR_OFFSET_LED3   = 3'd1,
      CSR_START_GROUP1  = 3'd2,
      CSR_START_GROUP2  = 3'd3,
      CSR_START_GROUP3  = 3'd4
   } csr_index_type;

   // member codes
   localparam member_type MEMBER_FIRST = 2'd0;
   localparam member_type MEMBER_MID   = 2'd1;
   localparam member_type MEMBER_LAST  = 2'd2;
   localparam member_type MEMBER_IDLE  = 2'd3;

   // reset values
   localparam cnt_type    RST_OFFSET_LED2 = 11'd400;
   localparam cnt_type    RST_OFFSET_LED3 = 11'd1200;
   localparam member_type RST_START_GROUP1 = MEMBER_FIRST;
   localparam member_type RST_START_GROUP2 = MEMBER_LAST;
   localparam member_type RST_START_GROUP3 = MEMBER_FIRST;

   // raised-cosine duty profile
   localparam duty_type DUTY_TABLE [DUTY_LEN] = '{
      8'd0,   8'd6,   8'd24,  8'd53,  8'd88,  8'd128, 8'd168, 8'd203, 8'd232, 8'd250,
      8'd255, 8'd250, 8'd232, 8'd203, 8'd168, 8'd128, 8'd88,  8'd53,  8'd24,  8'd6
   };

   typedef cnt_type seg_cnt_array_type [SEGMENTS];
   typedef ph_type  seg_thr_array_type [SEGMENTS];
   typedef ph_type  lo_mod_array_type [2**LO_W];
   typedef ph_type  hi_mod_array_type [2**HI_W];

   // per-group result handed from the segment logic to the state update
   typedef struct packed {
      logic       active;
      logic       level;
      logic       wrap;
      cnt_type    cnt_next;
      member_type member_next;
   } grp_res_type;

   // first counter value that falls in each segment
   function automatic seg_cnt_array_type seg_start_table();
      seg_cnt_array_type t;
      for (int k = 0; k < SEGMENTS; k++) begin
         t[k] = CNT_W'((k * TICKS_PER_WAVE + SEGMENTS - 1) / SEGMENTS);
      end
      return t;
   endfunction

   // segment base counter value
   function automatic seg_cnt_array_type seg_base_table();
      seg_cnt_array_type t;
      for (int k = 0; k < SEGMENTS; k++) begin
         t[k] = CNT_W'((TICKS_PER_WAVE * k) / SEGMENTS);
      end
      return t;
   endfunction

   // pwm on-threshold for each segment
   function automatic seg_thr_array_type seg_thr_table();
      seg_thr_array_type t;
      int ti;
      for (int k = 0; k < SEGMENTS; k++) begin
         ti = (k * DUTY_LEN) / SEGMENTS;
         if (ti >= DUTY_LEN) ti = DUTY_LEN - 1;
         t[k] = PH_W'((int'(DUTY_TABLE[ti]) * PWM_PERIOD) >> 8);
      end
      return t;
   endfunction

   // low part of the in-segment offset, reduced by the pwm period
   function automatic lo_mod_array_type lo_mod_table();
      lo_mod_array_type t;
      for (int k = 0; k < 2**LO_W; k++) begin
         t[k] = PH_W'(k % PWM_PERIOD);
      end
      return t;
   endfunction

   // high part of the in-segment offset, reduced by the pwm period
   function automatic hi_mod_array_type hi_mod_table();
      hi_mod_array_type t;
      for (int k = 0; k < 2**HI_W; k++) begin
         t[k] = PH_W'((k * (2**LO_W)) % PWM_PERIOD);
      end
      return t;
   endfunction

   localparam seg_cnt_array_type SEG_START = seg_start_table();
   localparam seg_cnt_array_type SEG_BASE  = seg_base_table();
   localparam seg_thr_array_type SEG_THR   = seg_thr_table();
   localparam lo_mod_array_type  LO_MOD    = lo_mod_table();
   localparam hi_mod_array_type  HI_MOD    = hi_mod_table();

endpackage

### sv/led_breathing_pwm_rotator_top.sv
// Nine-LED breathing driver in three groups of three. Each request is one millisecond tick:
// in every group the active LED steps its phase counter, its pin follows a raised-cosine
// PWM profile, and when the counter wraps the group passes to its next LED and flags the
// handover. A request with restart set clears the counters and reloads those of LEDs 2 and 3
// and the active members from the configuration registers instead. One request is accepted
// per clock cycle; its response sits in the output register from the following cycle. While a
// response waits there unaccepted the next request is held off, so a request every cycle needs
// rsp_ready high. Configuration is written through the csr port while no request is outstanding;
// the new values take effect at the next restart.
module led_breathing_pwm_rotator_top
   import lbpr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_restart,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [LEDS-1:0]      rsp_led_levels,
   output logic [GROUPS-1:0]    rsp_handover_flags,
   // configuration
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_wdata
);

   cnt_type     offset_led2_ff, offset_led3_ff;
   member_type  start_member_ff [GROUPS];
   cnt_type     counters_ff [LEDS];
   cnt_type     counters_in [LEDS];
   member_type  members_ff [GROUPS];
   member_type  members_in [GROUPS];
   logic [LEDS-1:0]   pin_image_ff, pin_image_in;
   logic [GROUPS-1:0] flags_ff, flags_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        req_accept;
   grp_res_type grp_res [GROUPS];

   // pin level for one phase counter value
   function automatic logic led_level(input cnt_type cnt);
      seg_type                seg;
      cnt_type                diff;
      logic [PH_SUM_W-1:0]    sum;
      ph_type                 phase;
      seg = '0;
      for (int k = 1; k < SEGMENTS; k++) begin
         if (cnt >= SEG_START[k]) seg = SEG_W'(k);
      end
      diff = cnt - SEG_BASE[seg];
      sum  = {1'b0, HI_MOD[diff[CNT_W-1:LO_W]]} + {1'b0, LO_MOD[diff[LO_W-1:0]]};
      if (sum >= PH_SUM_W'(PWM_PERIOD)) sum = sum - PH_SUM_W'(PWM_PERIOD);
      phase = sum[PH_W-1:0];
      return phase < SEG_THR[seg];
   endfunction

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_led2_ff     <= RST_OFFSET_LED2;
         offset_led3_ff     <= RST_OFFSET_LED3;
         start_member_ff[0] <= RST_START_GROUP1;
         start_member_ff[1] <= RST_START_GROUP2;
         start_member_ff[2] <= RST_START_GROUP3;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OFFSET_LED2:  offset_led2_ff     <= csr_wdata;
            CSR_OFFSET_LED3:  offset_led3_ff     <= csr_wdata;
            CSR_START_GROUP1: start_member_ff[0] <= csr_wdata[MEMBER_W-1:0];
            CSR_START_GROUP2: start_member_ff[1] <= csr_wdata[MEMBER_W-1:0];
            CSR_START_GROUP3: start_member_ff[2] <= csr_wdata[MEMBER_W-1:0];
            default: ;
         endcase
      end
   end

   // per-group segment lookup, pwm compare and counter step
   for (genvar g = 0; g < GROUPS; g++) begin : g_group
      always_comb begin
         cnt_type          cnt;
         logic [CNT_W:0]   inc;
         member_type       m;
         m = members_ff[g];
         case (m)
            MEMBER_FIRST: cnt = counters_ff[g];
            MEMBER_MID:   cnt = counters_ff[g + GROUPS];
            MEMBER_LAST:  cnt = counters_ff[g + 2 * GROUPS];
            default:      cnt = counters_ff[g];
         endcase
         inc = {1'b0, cnt} + 1'b1;
         grp_res[g].active   = (m != MEMBER_IDLE);
         grp_res[g].level    = led_level(cnt);
         grp_res[g].wrap     = grp_res[g].active && (inc >= (CNT_W+1)'(TICKS_PER_WAVE));
         grp_res[g].cnt_next = grp_res[g].wrap ? '0 : inc[CNT_W-1:0];
         if (!grp_res[g].wrap) begin
            grp_res[g].member_next = m;
         end else if (m == MEMBER_LAST) begin
            grp_res[g].member_next = MEMBER_FIRST;
         end else begin
            grp_res[g].member_next = m + 1'b1;
         end
      end
   end

   // next state on an accepted request
   always_comb begin
      counters_in  = counters_ff;
      members_in   = members_ff;
      pin_image_in = pin_image_ff;
      flags_in     = flags_ff;
      if (req_accept) begin
         flags_in = '0;
         if (req_restart) begin
            for (int l = 0; l < LEDS; l++) counters_in[l] = '0;
            counters_in[1] = offset_led2_ff;
            counters_in[2] = offset_led3_ff;
            for (int g = 0; g < GROUPS; g++) members_in[g] = start_member_ff[g];
         end else begin
            for (int g = 0; g < GROUPS; g++) begin
               members_in[g] = grp_res[g].member_next;
               flags_in[g]   = grp_res[g].wrap;
               for (int k = 0; k < MEMBERS; k++) begin
                  if (grp_res[g].active && members_ff[g] == MEMBER_W'(k)) begin
                     counters_in[g + GROUPS * k]  = grp_res[g].cnt_next;
                     pin_image_in[g + GROUPS * k] = grp_res[g].level;
                  end
               end
            end
         end
      end
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // state and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < LEDS; l++) counters_ff[l] <= '0;
         counters_ff[1] <= RST_OFFSET_LED2;
         counters_ff[2] <= RST_OFFSET_LED3;
         members_ff[0]  <= RST_START_GROUP1;
         members_ff[1]  <= RST_START_GROUP2;
         members_ff[2]  <= RST_START_GROUP3;
         pin_image_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         counters_ff  <= counters_in;
         members_ff   <= members_in;
         pin_image_ff <= pin_image_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // handover flags are payload only
   always_ff @(posedge clock) begin
      flags_ff <= flags_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_led_levels     = pin_image_ff;
   assign rsp_handover_flags = flags_ff;

   // a restart never reports a handover
   a_restart_no_flags: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_restart |=> rsp_handover_flags == '0)
      else $error("handover flagged on restart");

   // restart loads the start members
   a_restart_members: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_restart |=> members_ff[0] == $past(start_member_ff[0])
         && members_ff[1] == $past(start_member_ff[1])
         && members_ff[2] == $past(start_member_ff[2]))
      else $error("start members not loaded on restart");

   // pins only move on an accepted request
   a_pins_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(pin_image_ff))
      else $error("pin image changed without a request");

   // an idle group never hands over (checked for group 0)
   a_idle_group0: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_restart && members_ff[0] == MEMBER_IDLE
         |=> !rsp_handover_flags[0] && members_ff[0] == MEMBER_IDLE)
      else $error("idle group handed over");

endmodule

### tb/sv/led_breathing_pwm_rotator_top_tb.sv
module led_breathing_pwm_rotator_top_tb;
   import lbpr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_TICKS = 550;
   localparam int LONG_RUN     = 200;

   typedef struct packed {
      logic [LEDS-1:0]   led_levels;
      logic [GROUPS-1:0] handover_flags;
   } pin_frame_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_restart = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [LEDS-1:0]      rsp_led_levels;
   logic [GROUPS-1:0]    rsp_handover_flags;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CNT_W-1:0]     csr_wdata = '0;

   // own copy of the breathing state and its registers
   cnt_type         phase_cnt [LEDS];
   member_type      active_mbr [GROUPS];
   logic [LEDS-1:0] pin_state;
   cnt_type         led2_offset;
   cnt_type         led3_offset;
   member_type      start_mbr [GROUPS];

   bit            tick_queue [$];
   pin_frame_type pins_expected_q [$];
   int            ticks_issued = 0;
   int            ticks_taken = 0;
   int            fail_count = 0;
   int            cycle_count = 0;
   logic          req_taken = 1'b0;
   logic          steady = 1'b0;

   led_breathing_pwm_rotator_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_led_levels     (rsp_led_levels),
      .rsp_handover_flags (rsp_handover_flags),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // pin level of an active led for a given phase count
   function automatic bit led_is_lit(cnt_type c);
      int seg;
      int base;
      int ph;
      int ti;
      int duty;
      seg = (int'(c) * SEGMENTS) / TICKS_PER_WAVE;
      if (seg >= SEGMENTS) seg = SEGMENTS - 1;
      base = (TICKS_PER_WAVE * seg) / SEGMENTS;
      ph = ((int'(c) >= base) ? int'(c) - base : 0) % PWM_PERIOD;
      ti = (seg * DUTY_LEN) / SEGMENTS;
      if (ti >= DUTY_LEN) ti = DUTY_LEN - 1;
      duty = int'(DUTY_TABLE[ti]);
      return ph < ((duty * PWM_PERIOD) >> 8);
   endfunction

   // counters and members back to their starting values
   function automatic void reload_counters();
      for (int i = 0; i < LEDS; i++) phase_cnt[i] = '0;
      phase_cnt[1] = led2_offset;
      phase_cnt[2] = led3_offset;
      for (int g = 0; g < GROUPS; g++) active_mbr[g] = start_mbr[g];
   endfunction

   // one tick of every group, result queued for comparison
   function automatic void glow_step(logic restart);
      pin_frame_type f;
      member_type    m;
      cnt_type       c;
      int            led;
      f.handover_flags = '0;
      if (restart) begin
         reload_counters();
      end else begin
         for (int g = 0; g < GROUPS; g++) begin
            m = active_mbr[g];
            if (m != MEMBER_IDLE) begin
               led = g + GROUPS * int'(m);
               c = phase_cnt[led];
               pin_state[led] = led_is_lit(c);
               if (int'(c) + 1 < TICKS_PER_WAVE) begin
                  phase_cnt[led] = c + 1'b1;
               end else begin
                  phase_cnt[led] = '0;
                  active_mbr[g] = (m == MEMBER_LAST) ? MEMBER_FIRST : member_type'(m + 1'b1);
                  f.handover_flags[g] = 1'b1;
               end
            end
         end
      end
      f.led_levels = pin_state;
      pins_expected_q.push_back(f);
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (tick_queue.size() != 0 && (steady || $urandom_range(99) >= 8)) begin
            req_valid   <= 1'b1;
            req_restart <= tick_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 8);
   end

   // monitor: check responses, then predict for the request taken at this edge
   always @(posedge clock) begin
      pin_frame_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pins_expected_q.size() == 0) begin
               $error("response with no request outstanding: led_levels %h", rsp_led_levels);
               fail_count++;
            end else begin
               want = pins_expected_q.pop_front();
               if (rsp_led_levels !== want.led_levels) begin
                  $error("led_levels expected %h got %h", want.led_levels, rsp_led_levels);
                  fail_count++;
               end
               if (rsp_handover_flags !== want.handover_flags) begin
                  $error("handover_flags expected %h got %h",
                         want.handover_flags, rsp_handover_flags);
                  fail_count++;
               end
            end
         end
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            glow_step(req_restart);
            ticks_taken++;
         end
      end
   end

   task automatic push_tick(bit restart);
      tick_queue.push_back(restart);
      ticks_issued++;
   endtask

   // wait until every request is taken and answered
   task automatic settle();
      @(negedge clock);
      while (!(ticks_taken == ticks_issued && pins_expected_q.size() == 0)) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, cnt_type val);
      case (idx)
         CSR_OFFSET_LED2:  led2_offset  = val;
         CSR_OFFSET_LED3:  led3_offset  = val;
         CSR_START_GROUP1: start_mbr[0] = member_type'(val);
         CSR_START_GROUP2: start_mbr[1] = member_type'(val);
         CSR_START_GROUP3: start_mbr[2] = member_type'(val);
         default: ;
      endcase
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // offsets lean towards the wrap point so handovers come often
   function automatic cnt_type pick_offset();
      if ($urandom_range(1) == 0) return cnt_type'($urandom_range(1900, 2047));
      return cnt_type'($urandom_range(0, 2047));
   endfunction

   function automatic member_type pick_member();
      if ($urandom_range(9) == 0) return MEMBER_IDLE;
      return member_type'($urandom_range(2));
   endfunction

   task automatic set_registers(cnt_type o2, cnt_type o3, member_type m1, member_type m2,
                                member_type m3);
      csr_write(CSR_OFFSET_LED2, o2);
      csr_write(CSR_OFFSET_LED3, o3);
      csr_write(CSR_START_GROUP1, cnt_type'(m1));
      csr_write(CSR_START_GROUP2, cnt_type'(m2));
      csr_write(CSR_START_GROUP3, cnt_type'(m3));
   endtask

   // stimulus and end of run
   initial begin
      int random_ticks;
      int run_len;
      random_ticks = 0;
      led2_offset  = RST_OFFSET_LED2;
      led3_offset  = RST_OFFSET_LED3;
      start_mbr[0] = RST_START_GROUP1;
      start_mbr[1] = RST_START_GROUP2;
      start_mbr[2] = RST_START_GROUP3;
      reload_counters();
      pin_state = '0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ticks straight out of reset, then a restart with reset values
      repeat (3) push_tick(1'b0);
      push_tick(1'b1);
      repeat (2) push_tick(1'b0);
      settle();

      // counters just below the wrap and past the end of the wave
      set_registers(11'd1998, 11'd2047, MEMBER_FIRST, MEMBER_FIRST, MEMBER_FIRST);
      push_tick(1'b1);
      repeat (4) push_tick(1'b0);
      settle();

      // zero offset, last member and an idle group
      set_registers(11'd0, 11'd1999, MEMBER_LAST, MEMBER_MID, MEMBER_IDLE);
      push_tick(1'b1);
      repeat (3) push_tick(1'b0);
      push_tick(1'b1);
      push_tick(1'b0);
      settle();

      // a long stretch without gaps in which both offset leds wrap
      set_registers(11'd1990, 11'd1850, MEMBER_FIRST, MEMBER_FIRST, MEMBER_FIRST);
      steady = 1'b1;
      push_tick(1'b1);
      repeat (LONG_RUN) push_tick(1'b0);
      settle();
      steady = 1'b0;

      // random settings, each followed by a run of ticks with stray restarts
      while (random_ticks < RANDOM_TICKS) begin
         set_registers(pick_offset(), pick_offset(), pick_member(), pick_member(),
                       pick_member());
         if ($urandom_range(99) < 85) push_tick(1'b1);
         run_len = $urandom_range(10, 120);
         for (int k = 0; k < run_len; k++) begin
            push_tick($urandom_range(99) < 4);
            random_ticks++;
         end
         settle();
      end

      repeat (4) @(posedge clock);
      if (fail_count == 0 && pins_expected_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
